>>> sv/bba_pkg.sv
// Package: constants, codes and types for the block bitmap allocator.
`default_nettype none
package bba_pkg;
    localparam int MAX_BLOCKS = 4096;
    localparam int BMAP_DEPTH = (MAX_BLOCKS + 7) / 8;
    localparam int AW = $clog2(BMAP_DEPTH);
    localparam int BW = $clog2(MAX_BLOCKS);
    localparam int CW = BW + 1;

    typedef enum logic [2:0] {
        ACT_CNT_USED = 3'd0,
        ACT_CNT_FREE = 3'd1,
        ACT_TEST     = 3'd2,
        ACT_MARK_U   = 3'd3,
        ACT_MARK_F   = 3'd4,
        ACT_ALLOC    = 3'd5
    } t_action;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BOUNDS  = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_SMALL   = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_SCAN, S_SCAN_W, S_RANGE, S_RANGE_W,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]    action;
        logic [BW-1:0] block_start;
        logic [12:0]   block_count;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] result_value;
        logic        range_free;
    } t_rsp;
endpackage
`default_nettype wire

>>> sv/bba_if.sv
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface bba_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/bba_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> sv/block_bitmap_allocator.sv
// Top level: first-fit block bitmap allocator over a byte-wide RAM.
// One transaction at a time. After reset a clearing pass over all BMAP_DEPTH
// (512) bytes zeroes the bitmap before the first transaction is taken. Count
// and allocate walk the bitmap one byte at a time through the single RAM port
// (an address state, then a data state per byte; allocate then marks the
// bytes it takes in a second walk); test and mark walk the bytes covering the
// range the same way; mark does read-modify-write per byte. Each transaction also
// passes through a dispatch state and a result-load state.
// Results sit in an output register; a new transaction is taken once it is
// delivered.
`default_nettype none
module block_bitmap_allocator import bba_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    bba_if.sink              in_if,
    bba_if.source            out_if
);
    t_state r_state, n_state;
    logic [12:0] r_total;
    logic [9:0]  r_bytes;
    t_req        r_req;
    t_rsp        r_rsp, n_rsp;
    logic        r_oval, n_oval;
    logic [AW:0] r_idx, n_idx;      // byte pointer, one extra bit for end
    logic [AW:0] r_last, n_last;    // last byte (inclusive) for range walk
    logic [AW:0] r_run, n_run;      // free-run length in bytes
    logic [12:0] r_acc, n_acc;      // bit count
    logic [CW:0] r_lo, n_lo;        // range first block
    logic [CW:0] r_hi, n_hi;        // range end block (exclusive)
    logic        r_mark, n_mark;    // allocate marking phase
    t_req        n_req;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    bba_ram #(.WIDTH(8), .DEPTH(BMAP_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    // effective bounds
    logic [CW:0] eff_total;
    logic [AW:0] eff_bytes;
    assign eff_total = (r_total > 13'(MAX_BLOCKS)) ? (CW+1)'(MAX_BLOCKS)
                                                   : (CW+1)'(r_total);
    assign eff_bytes = ({1'b0, r_bytes} > 11'(BMAP_DEPTH)) ? (AW+1)'(BMAP_DEPTH)
                                                          : (AW+1)'(r_bytes);

    // mask of range bits inside the current byte
    logic [7:0] bmask;
    logic [3:0] pop;
    logic [AW+1:0] need;            // bytes wanted, up to 1024 for the largest count
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            bmask[b] = ({r_idx, 3'(b)} >= (AW+4)'(r_lo)) &&
                       ({r_idx, 3'(b)} <  (AW+4)'(r_hi));
        end
        pop = '0;
        for (int b = 0; b < 8; b++) pop = pop + 4'(ram_rdata[b]);
        need = (AW+2)'(({1'b0, r_req.block_count} + 14'd7) >> 3);
    end

    assign in_if.ready  = (r_state == S_IDLE) && !r_oval;
    assign out_if.valid = r_oval;
    assign out_if.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_total <= 13'd4096;
            r_bytes <= 10'd512;
            r_oval  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    1'b0:    r_total <= i_cfg_data;
                    default: r_bytes <= i_cfg_data[9:0];
                endcase
            end
        end
        r_req  <= n_req;
        r_rsp  <= n_rsp;
        r_last <= n_last;
        r_run  <= n_run;
        r_acc  <= n_acc;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mark <= n_mark;
    end

    always_comb begin
        n_state = r_state; n_oval = r_oval; n_idx = r_idx; n_req = r_req;
        n_rsp = r_rsp; n_last = r_last; n_run = r_run; n_acc = r_acc;
        n_lo = r_lo; n_hi = r_hi; n_mark = r_mark;
        ram_we = 1'b0; ram_addr = r_idx[AW-1:0]; ram_wdata = 8'h00;
        if (out_if.valid && out_if.ready) n_oval = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == (AW+1)'(BMAP_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_if.valid && in_if.ready) begin
                    n_req = in_if.data;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_rsp = '0; n_acc = '0; n_run = '0; n_idx = '0; n_mark = 1'b0;
                n_lo = (CW+1)'(r_req.block_start);
                n_hi = (CW+1)'(r_req.block_start) + (CW+1)'(r_req.block_count);
                n_last = (AW+1)'(n_hi - 1'b1 >> 3);
                n_state = S_OUT;
                case (r_req.action)
                    ACT_CNT_USED, ACT_CNT_FREE: begin
                        if (eff_bytes != '0) n_state = S_SCAN;
                    end
                    ACT_TEST, ACT_MARK_U, ACT_MARK_F: begin
                        if (n_hi > eff_total) begin
                            n_rsp.status = ST_BOUNDS;
                        end else if (r_req.block_count == '0) begin
                            n_rsp.range_free = (r_req.action == ACT_TEST);
                        end else begin
                            n_rsp.range_free = (r_req.action == ACT_TEST);
                            n_idx = (AW+1)'(n_lo >> 3);
                            n_state = S_RANGE;
                        end
                    end
                    ACT_ALLOC: begin
                        if (r_req.block_count < 13'd8) n_rsp.status = ST_SMALL;
                        else if (eff_bytes == '0) n_rsp.status = ST_NOSPACE;
                        else n_state = S_SCAN;
                    end
                    default: ;
                endcase
            end
            S_SCAN: n_state = S_SCAN_W;   // address issued, wait for data
            S_SCAN_W: begin
                n_state = S_SCAN;
                n_idx = r_idx + 1'b1;
                if (r_req.action == ACT_ALLOC) begin
                    if (ram_rdata == 8'h00) begin
                        n_run = r_run + 1'b1;
                        if (n_run >= need) begin
                            n_lo = {(r_idx + 1'b1 - n_run), 3'b000};
                            n_hi = n_lo + (CW+1)'(r_req.block_count);
                            if (n_hi > eff_total) begin
                                n_rsp.status = ST_BOUNDS;
                                n_state = S_OUT;
                            end else begin
                                n_rsp.result_value = 13'(n_lo);
                                n_idx = r_idx + 1'b1 - n_run;
                                n_last = (AW+1)'(n_hi - 1'b1 >> 3);
                                n_mark = 1'b1;
                                n_state = S_RANGE;
                            end
                        end
                    end else begin
                        n_run = '0;
                    end
                end else begin
                    n_acc = r_acc + ((r_req.action == ACT_CNT_USED) ?
                                     13'(pop) : 13'(4'd8 - pop));
                    n_rsp.result_value = n_acc;
                end
                if (n_state == S_SCAN && n_idx == eff_bytes) begin
                    if (r_req.action == ACT_ALLOC) n_rsp.status = ST_NOSPACE;
                    n_state = S_OUT;
                end
            end
            S_RANGE: n_state = S_RANGE_W;
            S_RANGE_W: begin
                n_state = S_RANGE;
                if (r_req.action == ACT_TEST && !r_mark) begin
                    if ((ram_rdata & bmask) != 8'h00) begin
                        n_rsp.range_free = 1'b0;
                        n_state = S_OUT;
                    end
                end else begin
                    ram_we = 1'b1;
                    ram_wdata = (r_req.action == ACT_MARK_F && !r_mark) ?
                                (ram_rdata & ~bmask) : (ram_rdata | bmask);
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == r_last) n_state = S_OUT;
            end
            S_OUT: begin
                n_oval = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_if.valid && in_if.ready |-> r_state == S_IDLE)
        else $error("accept while busy");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid && !out_if.ready |=> out_if.valid && $stable(r_rsp))
        else $error("result dropped");
    a_one_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> !r_oval)
        else $error("result overwritten");
endmodule
`default_nettype wire

>>> tb/sv/bba_checker.sv
`timescale 1ns / 100ps
// Checker: watches the request and response channels, predicts each response and compares.
module bba_checker import bba_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    bba_if                   req_mon,
    bba_if                   rsp_mon,
    output int               o_errors,
    output int               o_pending
);
    localparam logic [0:0] REG_TOTAL = 1'd0;
    localparam logic [0:0] REG_BYTES = 1'd1;

    logic [7:0]  used_map [BMAP_DEPTH];
    logic [12:0] total_blocks;
    logic [9:0]  scan_bytes;
    t_rsp        rsp_queue [$];

    function automatic int lim_total();
        return (total_blocks > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_blocks);
    endfunction

    function automatic int lim_bytes();
        return (scan_bytes > BMAP_DEPTH) ? BMAP_DEPTH : int'(scan_bytes);
    endfunction

    function automatic void set_range(int first, int cnt, logic val);
        for (int b = first; b < first + cnt; b++)
            used_map[(b >> 3) % BMAP_DEPTH][b & 7] = val;
    endfunction

    // Applies one request to the shadow bitmap and returns the response it must give.
    function automatic t_rsp apply_request(t_req rq);
        t_rsp r;
        int start, cnt, need, run, first, nb;
        logic found;
        r = '0;
        start = int'(rq.block_start);
        cnt = int'(rq.block_count);
        nb = lim_bytes();
        case (rq.action)
            ACT_CNT_USED, ACT_CNT_FREE: begin
                for (int i = 0; i < nb; i++)
                    r.result_value += (rq.action == ACT_CNT_USED) ? 13'($countones(used_map[i]))
                                      : 13'(8 - $countones(used_map[i]));
            end
            ACT_TEST, ACT_MARK_U, ACT_MARK_F: begin
                if (start + cnt > lim_total()) begin
                    r.status = ST_BOUNDS;
                end else if (rq.action == ACT_TEST) begin
                    r.range_free = 1'b1;
                    for (int b = start; b < start + cnt; b++)
                        if (used_map[(b >> 3) % BMAP_DEPTH][b & 7]) r.range_free = 1'b0;
                end else begin
                    set_range(start, cnt, rq.action == ACT_MARK_U);
                end
            end
            ACT_ALLOC: begin
                if (cnt < 8) begin
                    r.status = ST_SMALL;
                end else begin
                    need = (cnt + 7) / 8;
                    run = 0;
                    first = 0;
                    found = 1'b0;
                    for (int i = 0; i < nb && !found; i++) begin
                        if (used_map[i] == 8'h00) begin
                            run++;
                            if (run >= need) begin
                                first = 8 * (i + 1 - run);
                                found = 1'b1;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                    if (!found) r.status = ST_NOSPACE;
                    else if (first + cnt > lim_total()) r.status = ST_BOUNDS;
                    else begin
                        set_range(first, cnt, 1'b1);
                        r.result_value = 13'(first);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign o_pending = rsp_queue.size();

    always @(posedge i_clk) begin
        t_rsp want, got;
        if (!i_rst_n) begin
            for (int i = 0; i < BMAP_DEPTH; i++) used_map[i] = 8'h00;
            total_blocks = 13'd4096;
            scan_bytes = 10'd512;
            rsp_queue.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TOTAL) total_blocks = i_cfg_data;
                else if (i_cfg_index == REG_BYTES) scan_bytes = i_cfg_data[9:0];
            end
            if (req_mon.valid && req_mon.ready)
                rsp_queue.push_back(apply_request(req_mon.data));
            if (rsp_mon.valid && rsp_mon.ready) begin
                got = rsp_mon.data;
                if (rsp_queue.size() == 0) begin
                    $display("%0t: response with none outstanding: %p", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = rsp_queue.pop_front();
                    if (got.status !== want.status || got.result_value !== want.result_value
                        || got.range_free !== want.range_free) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top: drives configuration and requests, stalls responses, reports the verdict.
module tb;
    import bba_pkg::*;

    localparam logic [0:0] REG_TOTAL = 1'd0;
    localparam logic [0:0] REG_BYTES = 1'd1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;
    int          n_errors;
    int          n_pending;
    logic        no_gaps = 1'b0;   // back-to-back stretches on the request side

    bba_if #(.T(t_req)) req_ch (i_clk);
    bba_if #(.T(t_rsp)) rsp_ch (i_clk);

    block_bitmap_allocator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .in_if(req_ch.sink), .out_if(rsp_ch.source)
    );

    bba_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .req_mon(req_ch), .rsp_mon(rsp_ch),
        .o_errors(n_errors), .o_pending(n_pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop: a timeout that reports failure if the run hangs
    initial begin
        #60ms;
        $display("block_bitmap_allocator test failed");
        $finish;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
    end

    // Response side: random stall before each transaction, sometimes none
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [12:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drop the request, drain all outstanding responses, then a little slack
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reconfigure(logic [12:0] total, logic [12:0] nbytes);
        wait_idle();
        write_reg(REG_TOTAL, total);
        write_reg(REG_BYTES, nbytes);
    endtask

    // One request transaction; valid stays high into the next one when no gap is drawn
    task automatic send_req(logic [2:0] act, logic [11:0] start, logic [12:0] cnt);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.data <= '{action: act, block_start: start, block_count: cnt};
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Mostly well-formed: allocs, marks, tests, counts; some out of bound or unknown
    task automatic random_reqs(int n, int total);
        int pick, lim;
        logic [11:0] s;
        logic [12:0] c;
        lim = (total > MAX_BLOCKS) ? MAX_BLOCKS : total;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            s = 12'($urandom_range(0, (lim > 0) ? lim - 1 : 0));
            c = 13'($urandom_range(0, 48));
            if ($urandom_range(0, 15) == 0) c = 13'($urandom_range(0, 8191));
            if ($urandom_range(0, 15) == 0) s = 12'($urandom);
            if (pick < 28) begin
                c = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 7))
                                                : 13'($urandom_range(8, 160));
                send_req(ACT_ALLOC, 12'($urandom), c);
            end else if (pick < 43) send_req(ACT_MARK_U, s, c);
            else if (pick < 60) send_req(ACT_MARK_F, s, c);
            else if (pick < 64) send_req(ACT_MARK_F, '0, 13'(lim));   // defragment
            else if (pick < 86) send_req(ACT_TEST, s, c);
            else if (pick < 92) send_req(ACT_CNT_USED, 12'($urandom), 13'($urandom));
            else if (pick < 97) send_req(ACT_CNT_FREE, 12'($urandom), 13'($urandom));
            else send_req(3'($urandom_range(6, 7)), 12'($urandom), 13'($urandom));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes and special cases at the reset configuration
        reconfigure(13'd4096, 13'd512);
        send_req(ACT_CNT_FREE, '0, '0);
        send_req(ACT_TEST, '0, 13'd0);                   // zero count test
        send_req(ACT_TEST, 12'd0, 13'd4096);
        send_req(ACT_TEST, 12'd4095, 13'd8191);          // past the end
        send_req(ACT_MARK_U, 12'd4095, 13'd1);
        send_req(ACT_MARK_U, 12'd4095, 13'd2);           // past the end
        send_req(ACT_MARK_U, 12'd100, 13'd0);            // zero count mark
        send_req(ACT_ALLOC, '0, 13'd0);                  // small allocation
        send_req(ACT_ALLOC, '0, 13'd7);
        send_req(ACT_ALLOC, '0, 13'd8);
        send_req(ACT_ALLOC, '0, 13'd4096);               // no run left
        send_req(ACT_MARK_F, 12'd0, 13'd4096);
        send_req(ACT_ALLOC, '0, 13'd4096);
        send_req(ACT_CNT_USED, 12'hfff, 13'h1fff);
        send_req(ACT_ALLOC, '0, 13'd8191);
        send_req(ACT_MARK_F, 12'd8, 13'd4000);
        send_req(ACT_TEST, 12'd4095, 13'd1);
        send_req(3'd6, 12'hfff, 13'h1fff);               // unknown actions
        send_req(3'd7, 12'h555, 13'h0aaa);
        send_req(ACT_CNT_FREE, '0, '0);
        random_reqs(120, 4096);

        // Allocations under a short bound and a short scanned range
        reconfigure(13'd1000, 13'd64);
        send_req(ACT_MARK_F, 12'd0, 13'd1000);
        send_req(ACT_ALLOC, '0, 13'd1000);
        send_req(ACT_ALLOC, '0, 13'd300);
        random_reqs(300, 1000);

        // Zero total and zero scanned bytes
        reconfigure(13'd0, 13'd0);
        send_req(ACT_CNT_USED, '0, '0);
        send_req(ACT_ALLOC, '0, 13'd8);
        send_req(ACT_TEST, 12'd0, 13'd0);
        send_req(ACT_TEST, 12'd0, 13'd1);
        random_reqs(60, 0);

        // Oversized registers clamp to the array size
        reconfigure(13'h1fff, 13'h3ff);
        random_reqs(80, 8191);

        reconfigure(13'd200, 13'd16);
        random_reqs(430, 200);

        reconfigure(13'd2048, 13'd1);
        random_reqs(150, 2048);

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("block_bitmap_allocator test passed");
        end else begin
            $display("block_bitmap_allocator test failed");
        end
        $finish;
    end
endmodule
